### rtl/lfr_pkg.sv
// ----------------------------------------------------------------------------
// lfr_pkg: shared constants and types for the LRU frame replacer
// Holds the frame count, the derived widths, the request codes and the
// per-cell control word.
// ----------------------------------------------------------------------------
package lfr_pkg;

  localparam int NUM_FRAMES = 64;
  localparam int FRAME_W    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int COUNT_W    = $clog2(NUM_FRAMES + 1);
  localparam int CAP_W      = 7;
  localparam int CMP_W      = (COUNT_W > CAP_W) ? COUNT_W : CAP_W;
  localparam int CAP_RESET  = 64;
  localparam int IN_DATA_W  = ((FRAME_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((FRAME_W + COUNT_W + 7) / 8) * 8;

  // request codes carried on the request tuser
  typedef enum logic [1:0] {
    REQ_VICTIM = 2'd0,
    REQ_PIN    = 2'd1,
    REQ_UNPIN  = 2'd2,
    REQ_SPARE  = 2'd3
  } req_t;

  // control word handed to each cell of the list
  typedef struct packed {
    logic shift;  // take the right neighbour's contents
    logic load;   // take the broadcast frame as new tail
  } cell_ctl_t;

endpackage

### rtl/lru_frame_replacer.sv
// ----------------------------------------------------------------------------
// lru_frame_replacer: LRU list of evictable buffer frames
// One request in flight: requests are taken only in idle, then pass through the
// hit compare, removal prefix and apply steps; apply waits while the previous
//   result is still held downstream.
// Reset: synchronous, active high; empties the list, capacity returns to 64.
// ----------------------------------------------------------------------------
module lru_frame_replacer (
  input  logic                           clk,
  input  logic                           rst,
  // configuration: capacity register
  input  logic                           cfg_we,
  input  logic [lfr_pkg::CAP_W-1:0]      cfg_wdata,
  // request side
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [lfr_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // [5:0] frame_index
  input  logic [1:0]                     s_axis_tuser,   // [1:0] req_type
  // result side
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [lfr_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // [5:0] evict_frame,
                                                         // [12:6] evictable_count
  output logic                           m_axis_tuser    // [0] victim_found
);

  localparam int N = lfr_pkg::NUM_FRAMES;
  localparam int W = lfr_pkg::FRAME_W;
  localparam int C = lfr_pkg::COUNT_W;
  localparam int STEPS = (N > 1) ? $clog2(N) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HIT,
    ST_SHIFT,
    ST_APPLY
  } state_t;

  state_t                   state;
  lfr_pkg::req_t            req_kind;
  logic [W-1:0]             req_frame;
  logic [lfr_pkg::CAP_W-1:0] capacity;
  logic [C-1:0]             length;
  logic [C-1:0]             len_after;
  logic [N-1:0]             hit_vec;
  logic [N-1:0]             shift_vec;
  logic                     removed;
  logic [W-1:0]             victim_hold;

  logic                     out_valid;
  logic                     out_found;
  logic [W-1:0]             out_frame;
  logic [C-1:0]             out_count;

  // cell row signals
  logic [N-1:0][W-1:0]      cell_frame;
  logic [N-1:0]             cell_valid;
  logic [N-1:0]             cell_hit;
  lfr_pkg::cell_ctl_t [N-1:0] cell_ctl;

  // combinational helpers
  logic [N-1:0]             rem_vec;
  logic [N-1:0]             prefix_vec;
  logic [N-1:0]             load_vec;
  logic                     apply_go;
  logic                     in_range;
  logic                     append_ok;

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_found;
  assign m_axis_tdata  = lfr_pkg::OUT_DATA_W'({out_count, out_frame});

  // Hold the result stage until the downstream side has taken the last one.
  assign apply_go = (state == ST_APPLY) && (!out_valid || m_axis_tready);

  assign in_range  = ({1'b0, req_frame} < (W + 1)'(N));
  // After any removal, an unpin appends only while the list is still under capacity.
  assign append_ok = (req_kind == lfr_pkg::REQ_UNPIN) && in_range &&
                     (lfr_pkg::CMP_W'(len_after) < lfr_pkg::CMP_W'(capacity));

  // Pick the cell to drop: the front for a victim, the matching cell for pin or unpin, none for the spare code.
  always_comb begin
    rem_vec = '0;
    case (req_kind)
      lfr_pkg::REQ_VICTIM: rem_vec[0] = (length != '0);
      lfr_pkg::REQ_PIN, lfr_pkg::REQ_UNPIN: rem_vec = hit_vec;
      default: rem_vec = '0;
    endcase
  end

  // Every cell at or behind the dropped one takes its right neighbour:
  // prefix OR by doubling spans.
  always_comb begin
    prefix_vec = rem_vec;
    for (int k = 0; k < STEPS; k++) begin
      prefix_vec = prefix_vec | (prefix_vec << (1 << k));
    end
  end

  // The new tail lands at the first free position after the removal.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      load_vec[i] = append_ok && (len_after == C'(i));
    end
  end

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      logic [W-1:0] nb_frame;
      logic         nb_valid;

      if (g == N - 1) begin : g_last
        assign nb_frame = '0;
        assign nb_valid = 1'b0;
      end else begin : g_mid
        assign nb_frame = cell_frame[g+1];
        assign nb_valid = cell_valid[g+1];
      end

      assign cell_ctl[g].shift = apply_go && shift_vec[g];
      assign cell_ctl[g].load  = apply_go && load_vec[g];

      lfr_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .key         (req_frame),
        .ctl         (cell_ctl[g]),
        .right_frame (nb_frame),
        .right_valid (nb_valid),
        .frame       (cell_frame[g]),
        .valid       (cell_valid[g]),
        .hit         (cell_hit[g])
      );
    end
  endgenerate

  // Sequencer: take a request, register the hits, register the shift pattern,
  // then update the row and the length and present the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      length    <= '0;
      capacity  <= lfr_pkg::CAP_W'(lfr_pkg::CAP_RESET);
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      // raise on a new result, drop once the downstream side takes it
      if (apply_go) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state <= ST_HIT;
          end
        end
        ST_HIT: begin
          state <= ST_SHIFT;
        end
        ST_SHIFT: begin
          state <= ST_APPLY;
        end
        ST_APPLY: begin
          if (apply_go) begin
            length    <= len_after + C'(append_ok);
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Payload registers: request, hit and shift vectors, result fields.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_axis_tvalid) begin
      req_kind  <= lfr_pkg::req_t'(s_axis_tuser);
      req_frame <= s_axis_tdata[W-1:0];
    end
    if (state == ST_HIT) begin
      hit_vec <= cell_hit;
    end
    if (state == ST_SHIFT) begin
      shift_vec   <= prefix_vec;
      removed     <= |rem_vec;
      len_after   <= length - C'(|rem_vec);
      victim_hold <= cell_frame[0];
    end
    if (apply_go) begin
      out_found <= (req_kind == lfr_pkg::REQ_VICTIM) && removed;
      out_frame <= ((req_kind == lfr_pkg::REQ_VICTIM) && removed) ? victim_hold : '0;
      out_count <= len_after + C'(append_ok);
    end
  end

endmodule

### rtl/lfr_cell.sv
// ----------------------------------------------------------------------------
// lfr_cell: one position of the ordered frame list
// Holds a frame and its valid bit, compares against the broadcast key and
// shifts in its right neighbour or loads the key as the new tail.
// ----------------------------------------------------------------------------
module lfr_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lfr_pkg::FRAME_W-1:0] key,
  input  lfr_pkg::cell_ctl_t          ctl,
  input  logic [lfr_pkg::FRAME_W-1:0] right_frame,
  input  logic                        right_valid,
  output logic [lfr_pkg::FRAME_W-1:0] frame,
  output logic                        valid,
  output logic                        hit
);

  assign hit = valid && (frame == key);

  // load wins over shift: the new tail lands where the list ends
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      frame <= key;
    end else if (ctl.shift) begin
      frame <= right_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.load) begin
      valid <= 1'b1;
    end else if (ctl.shift) begin
      valid <= right_valid;
    end
  end

endmodule
